/* rtl/emrf_pkg.sv */
// emrf_pkg: constants, codes and types for the ethernet mac register file
// depends on nothing; imported by ethernet_mac_register_file, emrf_lanes and the bench
`default_nettype none

package emrf_pkg;

  localparam int unsigned WINDOW_BYTES = 8192;
  localparam int unsigned WORD_COUNT   = WINDOW_BYTES / 4;
  localparam int unsigned ADDR_W       = $clog2(WORD_COUNT);
  localparam int unsigned OFF_W        = 14;

  typedef logic [ADDR_W-1:0] word_idx_t;
  typedef logic [OFF_W-1:0]  offset_t;

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2,
    SIZE_WIDE = 2'd3
  } size_e;

  localparam offset_t OFF_INT_STATUS  = 14'h00B0;
  localparam offset_t OFF_RXTX_STATUS = 14'h00B8;
  localparam offset_t OFF_VERSION     = 14'h0110;
  localparam offset_t OFF_DEBUG       = 14'h0114;
  localparam offset_t OFF_FEAT0       = 14'h011C;
  localparam offset_t OFF_FEAT1       = 14'h0120;
  localparam offset_t OFF_FEAT2       = 14'h0124;
  localparam offset_t OFF_FEAT3       = 14'h0128;
  localparam offset_t OFF_MDIO_ADDR   = 14'h0200;
  localparam offset_t OFF_MDIO_DATA   = 14'h0204;
  localparam offset_t OFF_MTL_STATUS  = 14'h0C20;
  localparam offset_t OFF_DMA_MODE    = 14'h1000;
  localparam offset_t OFF_DMA_STATUS  = 14'h1008;
  localparam offset_t OFF_DMA_DEBUG   = 14'h100C;

  localparam logic [31:0] VERSION_VALUE = 32'h0000_0051;
  localparam logic [31:0] MDIO_BUSY     = 32'h0000_0001;
  localparam logic [31:0] PHY_EVENT     = 32'h0000_0008;
  localparam logic [31:0] SOFT_RESET    = 32'h0000_0001;
  localparam logic [31:0] MDIO_DATA_KEEP = 32'hFFFF_0000;
  localparam logic [31:0] MDIO_DATA_FILL = 32'h0000_FFFF;

  function automatic word_idx_t word_idx(offset_t off);
    return off[2 +: ADDR_W];
  endfunction

endpackage

`default_nettype wire

/* rtl/ethernet_mac_register_file.sv */
// ethernet_mac_register_file: 32-bit register window in one synchronous ram
// depends on emrf_pkg, emrf_ram, emrf_lanes
// strobe_o comes the cycle after accept for out-of-window accesses and writes to
// read-only words; for all other accesses it is registered from the access state
// busy is high in the access state, and also in the int and dat states for a write to
// mdio address with busy set; after reset it stays high while the ram is cleared to zero
`default_nettype none

module ethernet_mac_register_file (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire emrf_pkg::action_e       action_i,
  input  wire emrf_pkg::offset_t       byte_offset_i,
  input  wire emrf_pkg::size_e         access_size_i,
  input  wire logic             [31:0] write_data_i,
  output logic                         strobe_o,
  output logic                  [31:0] read_data_o,
  output logic                         out_of_window_o
);
  import emrf_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ACC   = 3'd2;
  localparam logic [2:0] ST_INT   = 3'd3;
  localparam logic [2:0] ST_DAT   = 3'd4;

  localparam word_idx_t LAST_IDX = ADDR_W'(WORD_COUNT - 1);

  function automatic logic is_read_only(offset_t aligned);
    return aligned == OFF_INT_STATUS || aligned == OFF_RXTX_STATUS ||
           aligned == OFF_VERSION    || aligned == OFF_DEBUG       ||
           aligned == OFF_FEAT0      || aligned == OFF_FEAT1       ||
           aligned == OFF_FEAT2      || aligned == OFF_FEAT3       ||
           aligned == OFF_MTL_STATUS || aligned == OFF_DMA_STATUS  ||
           aligned == OFF_DMA_DEBUG;
  endfunction

  logic [2:0]  state_q, state_d;
  word_idx_t   clr_q, clr_d;
  logic        strobe_q, strobe_d;
  logic [31:0] rdata_q, rdata_d;
  logic        oow_q, oow_d;

  action_e     act_q;
  word_idx_t   idx_q;
  logic [1:0]  pos_q;
  size_e       size_q;
  logic [31:0] wdata_q;
  logic        ver_q;

  offset_t     aligned_in;
  logic        in_window;
  logic        accept;

  logic        ram_we;
  word_idx_t   ram_waddr;
  logic [31:0] ram_wdata;
  word_idx_t   ram_raddr;
  logic [31:0] ram_rdata;

  logic [31:0] lane_word;
  logic [31:0] lane_rdata;
  logic [31:0] lane_merged;
  logic [31:0] new_word;
  logic        mdio_fire;

  assign aligned_in = {byte_offset_i[OFF_W-1:2], 2'b00};
  assign in_window  = {1'b0, byte_offset_i} < (OFF_W + 1)'(WINDOW_BYTES);
  assign accept     = start && !busy;

  assign busy            = (state_q != ST_IDLE);
  assign strobe_o        = strobe_q;
  assign read_data_o     = rdata_q;
  assign out_of_window_o = oow_q;

  assign lane_word = ver_q ? VERSION_VALUE : ram_rdata;

  emrf_lanes u_lanes (
    .word_i   (lane_word),
    .pos_i    (pos_q),
    .size_i   (size_q),
    .wdata_i  (wdata_q),
    .rdata_o  (lane_rdata),
    .merged_o (lane_merged)
  );

  assign mdio_fire = (idx_q == word_idx(OFF_MDIO_ADDR)) && ((lane_merged & MDIO_BUSY) != '0);

  always_comb begin
    new_word = lane_merged;
    if (idx_q == word_idx(OFF_DMA_MODE)) begin
      new_word = lane_merged & ~SOFT_RESET;
    end else if (mdio_fire) begin
      new_word = lane_merged & ~MDIO_BUSY;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    strobe_d  = 1'b0;
    rdata_d   = '0;
    oow_d     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = new_word;
    ram_raddr = word_idx(aligned_in);
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (!in_window) begin
            strobe_d = 1'b1;
            oow_d    = 1'b1;
          end else if (action_i == ACT_WRITE && is_read_only(aligned_in)) begin
            strobe_d = 1'b1;
          end else begin
            state_d = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        strobe_d  = 1'b1;
        ram_raddr = word_idx(OFF_INT_STATUS);
        if (act_q == ACT_READ) begin
          rdata_d = lane_rdata;
          state_d = ST_IDLE;
        end else begin
          ram_we  = 1'b1;
          state_d = mdio_fire ? ST_INT : ST_IDLE;
        end
      end
      ST_INT: begin
        ram_we    = 1'b1;
        ram_waddr = word_idx(OFF_INT_STATUS);
        ram_wdata = ram_rdata | PHY_EVENT;
        ram_raddr = word_idx(OFF_MDIO_DATA);
        state_d   = ST_DAT;
      end
      ST_DAT: begin
        ram_we    = 1'b1;
        ram_waddr = word_idx(OFF_MDIO_DATA);
        ram_wdata = (ram_rdata & MDIO_DATA_KEEP) | MDIO_DATA_FILL;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
    oow_q   <= oow_d;
    if (accept) begin
      act_q   <= action_i;
      idx_q   <= word_idx(aligned_in);
      pos_q   <= byte_offset_i[1:0];
      size_q  <= access_size_i;
      wdata_q <= write_data_i;
      ver_q   <= (aligned_in == OFF_VERSION);
    end
  end

  emrf_ram #(
    .WIDTH (32),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

/* rtl/emrf_ram.sv */
// emrf_ram: generic single-write, single-read synchronous ram, registered read
// depends on nothing
`default_nettype none

module emrf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/emrf_lanes.sv */
// emrf_lanes: byte-lane extract for reads and merge for writes
// depends on emrf_pkg
`default_nettype none

module emrf_lanes (
  input  wire logic               [31:0] word_i,
  input  wire logic               [1:0]  pos_i,
  input  wire emrf_pkg::size_e           size_i,
  input  wire logic               [31:0] wdata_i,
  output logic                    [31:0] rdata_o,
  output logic                    [31:0] merged_o
);
  import emrf_pkg::*;

  logic [31:0] lane_mask;
  logic [31:0] wr_mask;
  logic [4:0]  shamt;

  assign shamt = {pos_i, 3'b000};

  always_comb begin
    unique case (size_i)
      SIZE_BYTE: lane_mask = 32'h0000_00FF;
      SIZE_HALF: lane_mask = 32'h0000_FFFF;
      default:   lane_mask = 32'hFFFF_FFFF;
    endcase
  end

  // a word or wide access replaces the whole word, lanes below the position become zero
  assign wr_mask  = (size_i == SIZE_BYTE || size_i == SIZE_HALF) ? (lane_mask << shamt)
                                                                 : 32'hFFFF_FFFF;
  assign rdata_o  = (word_i >> shamt) & lane_mask;
  assign merged_o = (word_i & ~wr_mask) | ((wdata_i << shamt) & wr_mask);

endmodule

`default_nettype wire

/* tb/sv/ethernet_mac_register_file_tb.sv */
// ethernet_mac_register_file_tb: self-checking bench for the mac register window
// a directed table, then random reads and writes, checked against a shadow copy of the words
// depends on emrf_pkg and ethernet_mac_register_file
`timescale 1ns / 1ps

module ethernet_mac_register_file_tb;
  import emrf_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 6000;
  localparam int unsigned RANDOM_COUNT = 500;
  localparam int unsigned TAIL_CYCLES  = 8;

  typedef struct packed {
    logic [31:0] read_data;
    logic        out_of_window;
  } response_t;

  typedef struct packed {
    action_e     act;
    offset_t     off;
    size_e       sz;
    logic [31:0] wdata;
    logic        typed;
    logic [31:0] rd;
    logic        oow;
  } access_row_t;

  localparam offset_t HOT_OFFSETS [14] = '{
    OFF_INT_STATUS, OFF_RXTX_STATUS, OFF_VERSION, OFF_DEBUG, OFF_FEAT0, OFF_FEAT1,
    OFF_FEAT2, OFF_FEAT3, OFF_MDIO_ADDR, OFF_MDIO_DATA, OFF_MTL_STATUS, OFF_DMA_MODE,
    OFF_DMA_STATUS, OFF_DMA_DEBUG
  };

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  action_e     action_i;
  offset_t     byte_offset_i;
  size_e       access_size_i;
  logic [31:0] write_data_i;
  logic        strobe_o;
  logic [31:0] read_data_o;
  logic        out_of_window_o;

  logic [31:0] reg_shadow [WORD_COUNT];
  response_t   pending_responses [$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;

  // directed accesses; typed expectations only where obvious
  access_row_t directed_rows [25] = '{
    '{ACT_READ,  14'h0000,        SIZE_WORD, 32'h0,        1'b1, 32'h0,        1'b0},
    '{ACT_READ,  OFF_VERSION,     SIZE_WORD, 32'h0,        1'b1, VERSION_VALUE, 1'b0},
    '{ACT_READ,  OFF_VERSION,     SIZE_BYTE, 32'h0,        1'b1, VERSION_VALUE, 1'b0},
    '{ACT_WRITE, OFF_VERSION,     SIZE_WORD, 32'hFFFFFFFF, 1'b1, 32'h0,        1'b0},
    '{ACT_READ,  OFF_VERSION + 14'd1, SIZE_HALF, 32'h0,    1'b1, 32'h0,        1'b0},
    '{ACT_READ,  14'h2000,        SIZE_WORD, 32'h0,        1'b1, 32'h0,        1'b1},
    '{ACT_WRITE, 14'h3FFF,        SIZE_BYTE, 32'hFFFFFFFF, 1'b1, 32'h0,        1'b1},
    '{ACT_READ,  14'h3FFF,        SIZE_BYTE, 32'h0,        1'b1, 32'h0,        1'b1},
    '{ACT_WRITE, 14'h1FFC,        SIZE_WORD, 32'hFFFFFFFF, 1'b1, 32'h0,        1'b0},
    '{ACT_READ,  14'h1FFC,        SIZE_WORD, 32'h0,        1'b1, 32'hFFFFFFFF, 1'b0},
    '{ACT_READ,  14'h1FFF,        SIZE_HALF, 32'h0,        1'b1, 32'h000000FF, 1'b0},
    '{ACT_WRITE, 14'h0003,        SIZE_HALF, 32'h0000ABCD, 1'b1, 32'h0,        1'b0},
    '{ACT_READ,  14'h0000,        SIZE_WORD, 32'h0,        1'b0, 32'h0,        1'b0},
    '{ACT_WRITE, 14'h0001,        SIZE_WORD, 32'h12345678, 1'b1, 32'h0,        1'b0},
    '{ACT_READ,  14'h0002,        SIZE_WORD, 32'h0,        1'b0, 32'h0,        1'b0},
    '{ACT_WRITE, 14'h0004,        SIZE_WIDE, 32'hDEADBEEF, 1'b1, 32'h0,        1'b0},
    '{ACT_READ,  14'h0006,        SIZE_WIDE, 32'h0,        1'b0, 32'h0,        1'b0},
    '{ACT_WRITE, OFF_DMA_MODE,    SIZE_WORD, 32'hFFFFFFFF, 1'b1, 32'h0,        1'b0},
    '{ACT_READ,  OFF_DMA_MODE,    SIZE_WORD, 32'h0,        1'b1, 32'hFFFFFFFE, 1'b0},
    '{ACT_WRITE, OFF_MDIO_ADDR,   SIZE_BYTE, 32'h00000005, 1'b1, 32'h0,        1'b0},
    '{ACT_READ,  OFF_MDIO_ADDR,   SIZE_WORD, 32'h0,        1'b1, 32'h00000004, 1'b0},
    '{ACT_READ,  OFF_INT_STATUS,  SIZE_WORD, 32'h0,        1'b1, PHY_EVENT,    1'b0},
    '{ACT_READ,  OFF_MDIO_DATA,   SIZE_WORD, 32'h0,        1'b1, MDIO_DATA_FILL, 1'b0},
    '{ACT_WRITE, OFF_INT_STATUS,  SIZE_WORD, 32'h0,        1'b1, 32'h0,        1'b0},
    '{ACT_READ,  OFF_INT_STATUS,  SIZE_BYTE, 32'h0,        1'b1, PHY_EVENT,    1'b0}
  };

  ethernet_mac_register_file dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .byte_offset_i   (byte_offset_i),
    .access_size_i   (access_size_i),
    .write_data_i    (write_data_i),
    .strobe_o        (strobe_o),
    .read_data_o     (read_data_o),
    .out_of_window_o (out_of_window_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic response_t shadow_access(action_e act, offset_t off, size_e sz,
                                              logic [31:0] wdata);
    response_t   rsp;
    logic [31:0] lane_mask;
    logic [31:0] mask;
    logic [31:0] v;
    offset_t     aligned;
    int unsigned shift;
    int unsigned idx;
    rsp = '0;
    if (off >= WINDOW_BYTES) begin
      rsp.out_of_window = 1'b1;
      return rsp;
    end
    case (sz)
      SIZE_BYTE: lane_mask = 32'h0000_00FF;
      SIZE_HALF: lane_mask = 32'h0000_FFFF;
      default:   lane_mask = 32'hFFFF_FFFF;
    endcase
    aligned = {off[OFF_W-1:2], 2'b00};
    idx     = int'(off >> 2);
    shift   = off[1:0] * 8;
    if (act == ACT_READ) begin
      v = (aligned == OFF_VERSION) ? VERSION_VALUE : reg_shadow[idx];
      rsp.read_data = (v >> shift) & lane_mask;
      return rsp;
    end
    case (aligned)
      OFF_INT_STATUS, OFF_RXTX_STATUS, OFF_VERSION, OFF_DEBUG, OFF_FEAT0, OFF_FEAT1,
      OFF_FEAT2, OFF_FEAT3, OFF_MTL_STATUS, OFF_DMA_STATUS, OFF_DMA_DEBUG: return rsp;
      default: ;
    endcase
    mask = (lane_mask == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : lane_mask << shift;
    v    = (reg_shadow[idx] & ~mask) | ((wdata << shift) & mask);
    if (aligned == OFF_DMA_MODE) begin
      v &= ~SOFT_RESET;
    end else if (aligned == OFF_MDIO_ADDR && (v & MDIO_BUSY) != 0) begin
      v &= ~MDIO_BUSY;
      reg_shadow[OFF_INT_STATUS >> 2] |= PHY_EVENT;
      reg_shadow[OFF_MDIO_DATA >> 2] =
        (reg_shadow[OFF_MDIO_DATA >> 2] & MDIO_DATA_KEEP) | MDIO_DATA_FILL;
    end
    reg_shadow[idx] = v;
    return rsp;
  endfunction

  // mostly back to back or short gaps, now and then a long one
  function automatic int unsigned pick_gap(bit burst);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (burst || roll < 10) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got %h expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // called at a rising edge; returns at the edge that ends the gap
  task automatic run_access(input access_row_t row, input int unsigned gap);
    response_t predicted;
    action_i      <= row.act;
    byte_offset_i <= row.off;
    access_size_i <= row.sz;
    write_data_i  <= row.wdata;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy);
    predicted = shadow_access(row.act, row.off, row.sz, row.wdata);
    if (row.typed) pending_responses.push_back('{row.rd, row.oow});
    else pending_responses.push_back(predicted);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    response_t want;
    if (rst_ni) begin
      if (strobe_o) begin
        if (pending_responses.size() == 0) begin
          report_mismatch("unexpected transaction", read_data_o, 32'h0);
        end else begin
          want = pending_responses.pop_front();
          if (read_data_o !== want.read_data)
            report_mismatch("read_data", read_data_o, want.read_data);
          if (out_of_window_o !== want.out_of_window)
            report_mismatch("out_of_window", {31'b0, out_of_window_o},
                            {31'b0, want.out_of_window});
        end
      end
      idle_cycles <= ((start && !busy) || strobe_o) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("ethernet_mac_register_file: mismatch");
    $finish;
  end

  initial begin
    access_row_t row;
    int unsigned n;
    bit          burst;
    for (n = 0; n < WORD_COUNT; n++) reg_shadow[n] = 32'h0;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    action_i      <= ACT_READ;
    byte_offset_i <= '0;
    access_size_i <= SIZE_BYTE;
    write_data_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) run_access(directed_rows[i], pick_gap(1'b0));

    for (n = 0; n < RANDOM_COUNT; n++) begin
      burst     = ((n / 60) % 3) == 2;
      row       = '0;
      row.act   = action_e'($urandom_range(0, 1));
      row.sz    = size_e'($urandom_range(0, 3));
      row.wdata = $urandom;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: row.off = OFF_W'(HOT_OFFSETS[$urandom_range(0, 13)] + $urandom_range(0, 3));
        4, 5, 6:    row.off = OFF_W'($urandom_range(0, 63));
        7:          row.off = OFF_W'($urandom_range(WINDOW_BYTES - 64, WINDOW_BYTES - 1));
        8:          row.off = OFF_W'($urandom_range(0, WINDOW_BYTES - 1));
        default:    row.off = OFF_W'($urandom_range(WINDOW_BYTES, (1 << OFF_W) - 1));
      endcase
      run_access(row, (n == RANDOM_COUNT - 1) ? 1 : pick_gap(burst));
    end

    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ethernet_mac_register_file: match");
    end else begin
      $display("ethernet_mac_register_file: mismatch");
    end
    $finish;
  end

endmodule
